@@ hw/rtl/lsc_pkg.sv @@
// Shared types and constants for the LRU sector cache controller.
// Used by lru_sector_cache_controller_unit; depends on nothing.
package lsc_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int SECTOR_W    = 32;
  localparam int DEVICE_W    = 2;
  localparam int SLOT_W      = 6;
  localparam int ACTION_W    = 2;

  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SECTOR_W-1:0] sector;
    logic [DEVICE_W-1:0] device;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                fill;
    logic                copy_back;
    logic [SECTOR_W-1:0] back_sector;
    logic [DEVICE_W-1:0] back_device;
    logic                last;
  } rsp_t;

endpackage

@@ hw/rtl/lru_sector_cache_controller_unit.sv @@
// LRU sector cache controller: tag store, recency list and dirty marks of a
// fully associative write-back sector cache. Depends on lsc_pkg.
//
// Usage:
//   req channel (req, req_valid, req_stall) takes one read, write or flush
//   beat at a time; req_stall stays high while a beat is in work.
//   rsp channel (rsp, rsp_valid, rsp_stall) returns one beat per access and
//   one beat per dirty slot on flush; last marks the final beat of an item.
// Sequence:
//   An access walks the recency list with one tag compare per cycle until it
//   matches or reaches the last occupied position, then moves its slot to the
//   front of the list (S_SHIFT, unless it is already there, then S_SHEND) and
//   loads its beat (S_EMIT). The single read port of the list and tag memories
//   sets the pace of these walks. A flush reads each occupied slot in turn
//   (S_FRD, S_FTAG, S_FCHK), then releases its held beat in S_FEND. The next
//   request is taken once the block is back in idle. Unused action code 3 is
//   taken and gives no beat.
// Reset:
//   rst clears the occupancy count and all control state; tags, dirty marks
//   and the recency list are rewritten when a slot fills, so the block is
//   ready in the cycle after reset.
// Stall:
//   A result waits in the output register while rsp_stall is high; the block
//   still takes the next request and holds its own result until that register
//   frees up.
module lru_sector_cache_controller_unit #(
  parameter int ENTRIES = lsc_pkg::ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  lsc_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_stall,
  output lsc_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);

  localparam int SW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW       = $clog2(ENTRIES + 1);
  localparam int SLOT_W   = lsc_pkg::SLOT_W;
  localparam int SECTOR_W = lsc_pkg::SECTOR_W;
  localparam int DEVICE_W = lsc_pkg::DEVICE_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOOK  = 4'd1;
  localparam logic [3:0] S_SHIFT = 4'd2;
  localparam logic [3:0] S_SHEND = 4'd3;
  localparam logic [3:0] S_EMIT  = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FTAG  = 4'd6;
  localparam logic [3:0] S_FCHK  = 4'd7;
  localparam logic [3:0] S_FEND  = 4'd8;

  logic [3:0]          state;
  lsc_pkg::req_t       req_q;
  logic [CW-1:0]       count;

  // lookup walk
  logic [CW-1:0]       rp;
  logic                v1, v2;
  logic [SW-1:0]       p1, p2, s2;

  // front move
  logic [SW-1:0]       sel;
  logic [SW-1:0]       sh_i, sw_idx;
  logic                sh_issue, sv;
  lsc_pkg::rsp_t       res;

  // flush walk
  logic [SW-1:0]       fp, fs;
  lsc_pkg::rsp_t       pend;
  logic                pend_v;

  // memories
  logic [SW-1:0]       order_mem [ENTRIES];
  logic [SECTOR_W-1:0] tag_mem   [ENTRIES];
  logic [DEVICE_W-1:0] dev_mem   [ENTRIES];
  logic                dirty_mem [ENTRIES];
  logic [SW-1:0]       order_rd;
  logic [SECTOR_W-1:0] tag_rd;
  logic [DEVICE_W-1:0] dev_rd;
  logic                dirty_rd;

  logic [SW-1:0]       order_raddr, order_waddr, order_wdata;
  logic                order_we, tag_re, tag_we;
  logic                dirty_we, dirty_wdata;
  logic [SW-1:0]       dirty_waddr;

  logic                found, exhausted, decide_hit, decide_miss, miss_full;
  logic [SW-1:0]       miss_slot, dec_pos, dec_slot;
  lsc_pkg::rsp_t       dec_res;
  logic                out_free, out_load, fl_push, fend_push, emit_push, fchk_go;
  lsc_pkg::rsp_t       out_data;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    unique case (state)
      S_LOOK:  order_raddr = rp[SW-1:0];
      S_SHIFT: order_raddr = sh_i;
      S_FRD:   order_raddr = fp;
      default: order_raddr = '0;
    endcase
  end

  assign order_we    = (state == S_SHIFT && sv) || (state == S_SHEND);
  assign order_waddr = (state == S_SHEND) ? '0 : sw_idx + SW'(1);
  assign order_wdata = (state == S_SHEND) ? sel : order_rd;
  assign tag_re      = (state == S_LOOK) || (state == S_FTAG);

  assign found       = v2 && (tag_rd == req_q.sector);
  assign exhausted   = (count == '0) || (v2 && (CW'(p2) == count - CW'(1)));
  assign decide_hit  = (state == S_LOOK) && found;
  assign decide_miss = (state == S_LOOK) && !found && exhausted;
  assign miss_full   = (count == CW'(ENTRIES));
  assign miss_slot   = miss_full ? s2 : count[SW-1:0];
  assign tag_we      = decide_miss;

  always_comb begin
    dec_res = '0;
    if (found) begin
      dec_slot     = s2;
      dec_pos      = p2;
      dec_res.hit  = 1'b1;
    end else begin
      dec_slot     = miss_slot;
      dec_pos      = miss_full ? p2 : count[SW-1:0];
      dec_res.fill = 1'b1;
      if (miss_full && dirty_rd) begin
        dec_res.copy_back   = 1'b1;
        dec_res.back_sector = tag_rd;
        dec_res.back_device = dev_rd;
      end
    end
    dec_res.slot = SLOT_W'(dec_slot);
    dec_res.last = 1'b1;
  end

  assign fl_push   = (state == S_FCHK) && dirty_rd && pend_v && out_free;
  assign fend_push = (state == S_FEND) && pend_v && out_free;
  assign emit_push = (state == S_EMIT) && out_free;
  assign out_load  = fl_push || fend_push || emit_push;
  assign fchk_go   = (state == S_FCHK) && (!dirty_rd || !pend_v || out_free);

  // dirty marks: set by a write, kept by a read hit, cleared by a read fill or a flush
  assign dirty_we    = decide_hit || decide_miss || (fchk_go && dirty_rd);
  assign dirty_waddr = (state == S_FCHK) ? fs : dec_slot;
  assign dirty_wdata = (state == S_LOOK) &&
                       ((req_q.action == lsc_pkg::ACT_WRITE) || (found && dirty_rd));

  always_comb begin
    out_data = emit_push ? res : pend;
    if (fend_push) begin
      out_data.last = 1'b1;
    end
  end

  // memories: one write port, registered read
  always_ff @(posedge clk) begin
    if (order_we) begin
      order_mem[order_waddr] <= order_wdata;
    end
    order_rd <= order_mem[order_raddr];
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[miss_slot] <= req_q.sector;
      dev_mem[miss_slot] <= req_q.device;
    end
    if (dirty_we) begin
      dirty_mem[dirty_waddr] <= dirty_wdata;
    end
    if (tag_re) begin
      tag_rd   <= tag_mem[order_rd];
      dev_rd   <= dev_mem[order_rd];
      dirty_rd <= dirty_mem[order_rd];
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= out_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      sv        <= 1'b0;
      sh_issue  <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          v1 <= 1'b0;
          v2 <= 1'b0;
          if (req_valid) begin
            req_q <= req;
            rp    <= '0;
            fp    <= '0;
            if (req.action == lsc_pkg::ACT_READ || req.action == lsc_pkg::ACT_WRITE) begin
              state <= S_LOOK;
            end else if (req.action == lsc_pkg::ACT_FLUSH && count != '0) begin
              pend_v <= 1'b0;
              state  <= S_FRD;
            end
          end
        end

        S_LOOK: begin
          // three-deep walk: list read, tag read, compare
          v1 <= (rp != count);
          p1 <= rp[SW-1:0];
          if (rp != count) begin
            rp <= rp + CW'(1);
          end
          v2 <= v1;
          p2 <= p1;
          s2 <= order_rd;
          if (decide_hit || decide_miss) begin
            sel <= dec_slot;
            res <= dec_res;
            if (decide_miss && !miss_full) begin
              count <= count + CW'(1);
            end
            sv <= 1'b0;
            if (dec_pos == '0) begin
              state <= S_SHEND;
            end else begin
              sh_i     <= dec_pos - SW'(1);
              sh_issue <= 1'b1;
              state    <= S_SHIFT;
            end
          end
        end

        S_SHIFT: begin
          // read entry i, write it to i+1 in the next cycle, walking toward the front
          sv     <= sh_issue;
          sw_idx <= sh_i;
          if (sh_issue) begin
            if (sh_i == '0) begin
              sh_issue <= 1'b0;
            end else begin
              sh_i <= sh_i - SW'(1);
            end
          end
          if (sv && sw_idx == '0) begin
            state <= S_SHEND;
          end
        end

        S_SHEND: begin
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        S_FRD: begin
          state <= S_FTAG;
        end

        S_FTAG: begin
          fs    <= order_rd;
          state <= S_FCHK;
        end

        S_FCHK: begin
          // hold one dirty beat back so the final one can carry last
          if (fchk_go) begin
            if (dirty_rd) begin
              pend.hit         <= 1'b0;
              pend.slot        <= SLOT_W'(fs);
              pend.fill        <= 1'b0;
              pend.copy_back   <= 1'b1;
              pend.back_sector <= tag_rd;
              pend.back_device <= dev_rd;
              pend.last        <= 1'b0;
              pend_v           <= 1'b1;
            end
            if (CW'(fp) == count - CW'(1)) begin
              state <= S_FEND;
            end else begin
              fp    <= fp + SW'(1);
              state <= S_FRD;
            end
          end
        end

        S_FEND: begin
          if (!pend_v) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("occupancy count beyond slot count");

  a_count_only_on_fill: assert property (@(posedge clk) disable iff (rst)
    (!$stable(count) && !$past(rst)) |-> ($past(state) == S_LOOK))
    else $error("occupancy changed outside a lookup");

  a_emit_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> (rsp_valid && state == S_IDLE))
    else $error("access result not loaded");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.hit || rsp.fill || rsp.copy_back))
    else $error("result beat of no kind");

  a_flush_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FEND && fend_push) |=> !pend_v)
    else $error("held flush beat not released");
`endif

endmodule
